// ===== sv/rpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpcc_pkg: shared types and constants of the RTC prescaler/calendar counter
// Register codes, operation codes, bit positions and the item structs that
// pass between the top level and the core.
// ----------------------------------------------------------------------------
package rpcc_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      REG_CTRL  = 4'd0,
      REG_CON   = 4'd1,
      REG_T14   = 4'd2,
      REG_CNT   = 4'd3,
      REG_REL   = 4'd4,
      REG_ISNC  = 4'd5,
      REG_ALARM = 4'd6,
      REG_ISNRC = 4'd7,
      REG_ID    = 4'd8
   } reg_index_type;

   localparam logic [31:0] ID_VALUE       = 32'hF049_C011;
   localparam logic [31:0] CON_ACCPOS     = 32'h0000_8000;
   localparam logic [15:0] T14_RESET      = 16'd61440;
   localparam logic [15:0] TICK_MAX       = 16'hFFFF;
   localparam logic [31:0] ALARM_RESET    = 32'hFFFF_FFFF;

   localparam int CON_RUN = 0;
   localparam int CON_PRE = 1;
   localparam int CON_DEC = 2;
   localparam int CON_INC = 3;

   localparam int CTRL_INT     = 0;
   localparam int CTRL_BAD     = 1;
   localparam int CTRL_CLR_INT = 6;
   localparam int CTRL_CLR_BAD = 7;

   localparam logic [11:0] EN_MASK   = 12'h555;
   localparam logic [11:0] REQ_MASK  = 12'hAAA;
   localparam logic [11:0] REQ_T14   = 12'h002;
   localparam logic [11:0] REQ_FLD0  = 12'h008;
   localparam logic [11:0] REQ_FLD1  = 12'h020;
   localparam logic [11:0] REQ_FLD2  = 12'h080;
   localparam logic [11:0] REQ_FLD3  = 12'h200;
   localparam logic [11:0] REQ_ALARM = 12'h800;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_pulse;
      logic        int_flag;
   } result_type;

endpackage

// ===== sv/rpcc_core.sv =====
// ----------------------------------------------------------------------------
// rpcc_core: register file, tick counter, calendar and request logic
// Holds all RTC state and applies one item per cycle when fire is high,
// returning the result of that item.
// ----------------------------------------------------------------------------
module rpcc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  rpcc_pkg::item_type   item,
   input  logic                 cfg_write,
   input  logic [15:0]          cfg_value,
   output rpcc_pkg::result_type result
);

   logic [5:0]  control_ff,  control_in;
   logic [3:0]  mode_ff,     mode_in;
   logic [15:0] tick_ff,     tick_in;
   logic [15:0] reload_ff,   reload_in;
   logic [31:0] cal_ff,      cal_in;
   logic [31:0] cal_rel_ff,  cal_rel_in;
   logic [11:0] req_ff,      req_in;
   logic [31:0] alarm_ff,    alarm_in;
   logic [2:0]  pre_ff,      pre_in;

   logic [15:0] t_dec, t_adj;
   logic        inc_ok, overflow, go, count_now;
   logic [2:0]  pre_next;
   logic [31:0] cal_step;
   logic [3:0]  ones, carry;
   logic [11:0] raised, fresh, enabled;
   logic        irq;
   logic [31:0] rd;
   logic [31:0] wd;

   always_comb begin
      wd = item.write_data;

      pre_next  = pre_ff + 3'd1;
      go        = !mode_ff[rpcc_pkg::CON_PRE] || (pre_next == 3'd0);
      count_now = (rpcc_pkg::op_type'(item.op) == rpcc_pkg::OP_TICK)
                  && mode_ff[rpcc_pkg::CON_RUN] && go;

      t_dec    = mode_ff[rpcc_pkg::CON_DEC] ? tick_ff - 16'd1 : tick_ff;
      inc_ok   = mode_ff[rpcc_pkg::CON_INC] && (t_dec != rpcc_pkg::TICK_MAX);
      t_adj    = inc_ok ? t_dec + 16'd1 : t_dec;
      overflow = (t_adj == rpcc_pkg::TICK_MAX);

      ones[0]  = &cal_ff[9:0];
      ones[1]  = &cal_ff[15:10];
      ones[2]  = &cal_ff[21:16];
      ones[3]  = &cal_ff[31:22];
      carry[0] = 1'b1;
      carry[1] = ones[0];
      carry[2] = ones[0] & ones[1];
      carry[3] = ones[0] & ones[1] & ones[2];

      cal_step[9:0]   = !carry[0] ? cal_ff[9:0] :
                        ones[0] ? cal_rel_ff[9:0] : cal_ff[9:0] + 10'd1;
      cal_step[15:10] = !carry[1] ? cal_ff[15:10] :
                        ones[1] ? cal_rel_ff[15:10] : cal_ff[15:10] + 6'd1;
      cal_step[21:16] = !carry[2] ? cal_ff[21:16] :
                        ones[2] ? cal_rel_ff[21:16] : cal_ff[21:16] + 6'd1;
      cal_step[31:22] = !carry[3] ? cal_ff[31:22] :
                        ones[3] ? cal_rel_ff[31:22] : cal_ff[31:22] + 10'd1;

      raised = rpcc_pkg::REQ_T14
             | ((carry[0] & ones[0]) ? rpcc_pkg::REQ_FLD0 : 12'd0)
             | ((carry[1] & ones[1]) ? rpcc_pkg::REQ_FLD1 : 12'd0)
             | ((carry[2] & ones[2]) ? rpcc_pkg::REQ_FLD2 : 12'd0)
             | ((carry[3] & ones[3]) ? rpcc_pkg::REQ_FLD3 : 12'd0)
             | ((cal_ff == alarm_ff) ? rpcc_pkg::REQ_ALARM : 12'd0);
      fresh   = raised & ~req_ff & rpcc_pkg::REQ_MASK;
      enabled = {req_ff[10:0] & rpcc_pkg::EN_MASK[10:0], 1'b0};

      control_in = control_ff;
      mode_in    = mode_ff;
      tick_in    = tick_ff;
      reload_in  = reload_ff;
      cal_in     = cal_ff;
      cal_rel_in = cal_rel_ff;
      req_in     = req_ff;
      alarm_in   = alarm_ff;
      pre_in     = pre_ff;
      irq        = 1'b0;
      rd         = 32'd0;

      if (fire) begin
         unique case (rpcc_pkg::op_type'(item.op))
            rpcc_pkg::OP_TICK: begin
               if (mode_ff[rpcc_pkg::CON_RUN] && mode_ff[rpcc_pkg::CON_PRE]) begin
                  pre_in = pre_next;
               end
               if (count_now) begin
                  if (mode_ff[rpcc_pkg::CON_DEC]) begin
                     mode_in[rpcc_pkg::CON_DEC] = 1'b0;
                  end
                  if (inc_ok) begin
                     mode_in[rpcc_pkg::CON_INC] = 1'b0;
                  end
                  if (overflow) begin
                     tick_in = reload_ff;
                     cal_in  = cal_step;
                     req_in  = req_ff | raised;
                     irq     = |(fresh & enabled);
                     if (irq) begin
                        control_in[rpcc_pkg::CTRL_INT] = 1'b1;
                     end
                  end else begin
                     tick_in = t_adj + 16'd1;
                  end
               end
            end
            rpcc_pkg::OP_READ: begin
               unique case (rpcc_pkg::reg_index_type'(item.reg_index))
                  rpcc_pkg::REG_CTRL:  rd = {26'd0, control_ff};
                  rpcc_pkg::REG_CON:   rd = rpcc_pkg::CON_ACCPOS | {28'd0, mode_ff};
                  rpcc_pkg::REG_T14:   rd = {tick_ff, reload_ff};
                  rpcc_pkg::REG_CNT:   rd = cal_ff;
                  rpcc_pkg::REG_REL:   rd = cal_rel_ff;
                  rpcc_pkg::REG_ISNC:  rd = {20'd0, req_ff};
                  rpcc_pkg::REG_ALARM: rd = alarm_ff;
                  rpcc_pkg::REG_ID:    rd = rpcc_pkg::ID_VALUE;
                  default:             rd = 32'd0;
               endcase
            end
            rpcc_pkg::OP_WRITE: begin
               unique case (rpcc_pkg::reg_index_type'(item.reg_index))
                  rpcc_pkg::REG_CTRL: begin
                     control_in = {wd[5:2],
                                   control_ff[rpcc_pkg::CTRL_BAD] & ~wd[rpcc_pkg::CTRL_CLR_BAD],
                                   control_ff[rpcc_pkg::CTRL_INT] & ~wd[rpcc_pkg::CTRL_CLR_INT]};
                  end
                  rpcc_pkg::REG_CON: mode_in = wd[3:0];
                  rpcc_pkg::REG_T14: begin
                     tick_in   = wd[31:16];
                     reload_in = wd[15:0];
                  end
                  rpcc_pkg::REG_CNT:   cal_in = wd;
                  rpcc_pkg::REG_REL:   cal_rel_in = wd;
                  rpcc_pkg::REG_ISNC: begin
                     req_in = (wd[11:0] & rpcc_pkg::EN_MASK)
                            | (req_ff & wd[11:0] & rpcc_pkg::REQ_MASK);
                  end
                  rpcc_pkg::REG_ALARM: alarm_in = wd;
                  rpcc_pkg::REG_ISNRC: begin
                     req_in = req_ff & ~{wd[10:0] & rpcc_pkg::EN_MASK[10:0], 1'b0};
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      if (cfg_write) begin
         tick_in   = cfg_value;
         reload_in = cfg_value;
      end

      result.read_data = rd;
      result.irq_pulse = irq;
      result.int_flag  = control_in[rpcc_pkg::CTRL_INT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         mode_ff    <= 4'b0011;
         tick_ff    <= rpcc_pkg::T14_RESET;
         reload_ff  <= rpcc_pkg::T14_RESET;
         cal_ff     <= '0;
         cal_rel_ff <= '0;
         req_ff     <= '0;
         alarm_ff   <= rpcc_pkg::ALARM_RESET;
         pre_ff     <= '0;
      end else begin
         control_ff <= control_in;
         mode_ff    <= mode_in;
         tick_ff    <= tick_in;
         reload_ff  <= reload_in;
         cal_ff     <= cal_in;
         cal_rel_ff <= cal_rel_in;
         req_ff     <= req_in;
         alarm_ff   <= alarm_in;
         pre_ff     <= pre_in;
      end
   end

endmodule

// ===== sv/rtc_prescaler_calendar_counter_top.sv =====
// ----------------------------------------------------------------------------
// rtc_prescaler_calendar_counter_top: RTC with prescaler and calendar counter
// Input register, state core and result register with valid/stall handshake.
//
//   channel | direction | handshake      | payload
//   req_    | in        | valid / stall  | op, reg_index, write_data
//   rsp_    | out       | valid / stall  | read_data, irq_pulse, int_flag
//   csr_    | in        | valid / ready  | t14_reset_value
//
// One item per cycle unless the result is stalled; each result is registered.
// The state core updates all registers in the cycle an item leaves the
// input register, so the next item sees the new state at once.
// Synchronous active-high reset; no clearing pass.
// A stalled result holds; the input register moves on when the result
// register is empty or being taken. csr writes are taken while no item waits.
// ----------------------------------------------------------------------------
module rtc_prescaler_calendar_counter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_pulse,
   output logic        rsp_int_flag,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_t14_reset_value
);

   logic                 in_valid_ff;
   rpcc_pkg::item_type   in_item_ff;
   logic                 out_valid_ff;
   rpcc_pkg::result_type out_result_ff;
   rpcc_pkg::result_type core_result;
   logic                 advance;
   logic                 accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !in_valid_ff;

   rpcc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (in_item_ff),
      .cfg_write (csr_valid && csr_ready),
      .cfg_value (csr_t14_reset_value),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= '{op: req_op, reg_index: req_reg_index, write_data: req_write_data};
      end
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_result_ff.read_data;
   assign rsp_irq_pulse = out_result_ff.irq_pulse;
   assign rsp_int_flag  = out_result_ff.int_flag;

endmodule

// ===== dv/tb_rtc_prescaler_calendar_counter_top.sv =====
// ----------------------------------------------------------------------------
// tb_rtc_prescaler_calendar_counter_top: self-checking bench for the RTC
// Sends ticks, register reads and register writes through the req_ channel
// and loads the tick counter reset value through the csr_ port. Each result
// is checked field by field against an in-bench model of the counter chain,
// with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_rtc_prescaler_calendar_counter_top;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [3:0] REG_UNUSED   = 4'd15;
   localparam logic [5:0] CTRL_RW_BITS = 6'h3C;
   localparam int         HOLD_CYCLES  = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = rpcc_pkg::OP_TICK;
   logic [3:0]  req_reg_index = '0;
   logic [31:0] req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_pulse;
   logic        rsp_int_flag;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_t14_reset_value = '0;

   rtc_prescaler_calendar_counter_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_reg_index       (req_reg_index),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .rsp_irq_pulse       (rsp_irq_pulse),
      .rsp_int_flag        (rsp_int_flag),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_t14_reset_value (csr_t14_reset_value)
   );

   always #4 clock = ~clock;

   // model state
   logic [5:0]  ctl_bits;
   logic [3:0]  mode;
   logic [15:0] tick_cnt;
   logic [15:0] tick_rel;
   logic [31:0] cal_cnt;
   logic [31:0] cal_rel;
   logic [11:0] isn_bits;
   logic [31:0] alarm;
   logic [2:0]  pre_cnt;

   rpcc_pkg::result_type rtc_results_due[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int t14_loads = 0;
   int overflows = 0;
   int irqs_due = 0;
   int gap_pct = 25;
   int stall_pct = 25;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   function automatic rpcc_pkg::result_type rtc_next_result(logic [1:0] op,
                                                            logic [3:0] idx,
                                                            logic [31:0] wd);
      rpcc_pkg::result_type r;
      logic [11:0] raised;
      logic [11:0] fresh;
      logic [31:0] m;
      logic [31:0] v;
      logic        carry;
      logic        go;
      int          sh;
      r = '0;
      raised = '0;
      case (op)
         rpcc_pkg::OP_TICK: if (mode[rpcc_pkg::CON_RUN]) begin
            go = 1'b1;
            if (mode[rpcc_pkg::CON_PRE]) begin
               pre_cnt = pre_cnt + 3'd1;
               go = (pre_cnt == 3'd0);
            end
            if (go) begin
               if (mode[rpcc_pkg::CON_DEC]) begin
                  tick_cnt = tick_cnt - 16'd1;
                  mode[rpcc_pkg::CON_DEC] = 1'b0;
               end
               if (mode[rpcc_pkg::CON_INC] && tick_cnt != rpcc_pkg::TICK_MAX) begin
                  tick_cnt = tick_cnt + 16'd1;
                  mode[rpcc_pkg::CON_INC] = 1'b0;
               end
               if (tick_cnt != rpcc_pkg::TICK_MAX) begin
                  tick_cnt = tick_cnt + 16'd1;
               end else begin
                  overflows++;
                  tick_cnt = tick_rel;
                  raised = rpcc_pkg::REQ_T14;
                  if (cal_cnt == alarm) raised = raised | rpcc_pkg::REQ_ALARM;
                  carry = 1'b1;
                  for (int i = 0; i < 4 && carry; i++) begin
                     sh = (i == 0) ? 0 : (i == 1) ? 10 : (i == 2) ? 16 : 22;
                     m = (i == 1 || i == 2) ? 32'h3F : 32'h3FF;
                     v = (cal_cnt >> sh) & m;
                     carry = (v == m);
                     if (carry) begin
                        v = (cal_rel >> sh) & m;
                        raised = raised | (rpcc_pkg::REQ_FLD0 << (2 * i));
                     end else begin
                        v = v + 32'd1;
                     end
                     cal_cnt = (cal_cnt & ~(m << sh)) | (v << sh);
                  end
                  fresh = raised & ~isn_bits & rpcc_pkg::REQ_MASK;
                  isn_bits = isn_bits | raised;
                  if ((fresh & ((isn_bits & rpcc_pkg::EN_MASK) << 1)) != '0) begin
                     ctl_bits[rpcc_pkg::CTRL_INT] = 1'b1;
                     r.irq_pulse = 1'b1;
                     irqs_due++;
                  end
               end
            end
         end
         rpcc_pkg::OP_READ: case (idx)
            rpcc_pkg::REG_CTRL:  r.read_data = {26'd0, ctl_bits};
            rpcc_pkg::REG_CON:   r.read_data = {28'd0, mode} | rpcc_pkg::CON_ACCPOS;
            rpcc_pkg::REG_T14:   r.read_data = {tick_cnt, tick_rel};
            rpcc_pkg::REG_CNT:   r.read_data = cal_cnt;
            rpcc_pkg::REG_REL:   r.read_data = cal_rel;
            rpcc_pkg::REG_ISNC:  r.read_data = {20'd0, isn_bits};
            rpcc_pkg::REG_ALARM: r.read_data = alarm;
            rpcc_pkg::REG_ID:    r.read_data = rpcc_pkg::ID_VALUE;
            default:             r.read_data = '0;
         endcase
         rpcc_pkg::OP_WRITE: case (idx)
            rpcc_pkg::REG_CTRL: begin
               ctl_bits = (ctl_bits & ~CTRL_RW_BITS) | (wd[5:0] & CTRL_RW_BITS);
               if (wd[rpcc_pkg::CTRL_CLR_INT]) ctl_bits[rpcc_pkg::CTRL_INT] = 1'b0;
               if (wd[rpcc_pkg::CTRL_CLR_BAD]) ctl_bits[rpcc_pkg::CTRL_BAD] = 1'b0;
            end
            rpcc_pkg::REG_CON: mode = wd[3:0];
            rpcc_pkg::REG_T14: begin
               tick_cnt = wd[31:16];
               tick_rel = wd[15:0];
            end
            rpcc_pkg::REG_CNT:   cal_cnt = wd;
            rpcc_pkg::REG_REL:   cal_rel = wd;
            rpcc_pkg::REG_ISNC:  isn_bits = (wd[11:0] & rpcc_pkg::EN_MASK)
                                          | (isn_bits & wd[11:0] & rpcc_pkg::REQ_MASK);
            rpcc_pkg::REG_ALARM: alarm = wd;
            rpcc_pkg::REG_ISNRC: isn_bits = isn_bits
                                          & ~((wd[11:0] & rpcc_pkg::EN_MASK) << 1);
            default: ;
         endcase
         default: ;
      endcase
      r.int_flag = ctl_bits[rpcc_pkg::CTRL_INT];
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(logic [1:0] op, logic [3:0] idx, logic [31:0] wd);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_reg_index <= idx;
      req_write_data <= wd;
      do @(posedge clock); while (req_stall);
      rtc_results_due.push_back(rtc_next_result(op, idx, wd));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rtc_results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_t14_reset(logic [15:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_t14_reset_value <= value;
      do @(posedge clock); while (!csr_ready);
      tick_cnt = value;
      tick_rel = value;
      t14_loads++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_item();
      int pick;
      logic [3:0] idx;
      logic [31:0] wd;
      pick = $urandom_range(0, 99);
      idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                        : 4'($urandom_range(0, 8));
      wd = $urandom;
      if (pick < 55) begin
         send_item(rpcc_pkg::OP_TICK, idx, wd);
      end else if (pick < 72) begin
         send_item(rpcc_pkg::OP_READ, idx, wd);
      end else if (pick < 97) begin
         case (idx)
            rpcc_pkg::REG_CON: if ($urandom_range(0, 4) != 0) wd[rpcc_pkg::CON_RUN] = 1'b1;
            rpcc_pkg::REG_T14: if ($urandom_range(0, 3) != 0)
               wd = {rpcc_pkg::TICK_MAX - 16'($urandom_range(0, 20)),
                     rpcc_pkg::TICK_MAX - 16'($urandom_range(0, 40))};
            rpcc_pkg::REG_CNT: case ($urandom_range(0, 3))
               1: wd[9:0] = 10'h3FF - 10'($urandom_range(0, 2));
               2: wd[15:0] = 16'hFFFF - 16'($urandom_range(0, 2));
               3: wd = ~32'($urandom_range(0, 2));
               default: ;
            endcase
            rpcc_pkg::REG_ALARM: if ($urandom_range(0, 1) != 0)
               wd = cal_cnt + 32'($urandom_range(0, 2));
            default: ;
         endcase
         send_item(rpcc_pkg::OP_WRITE, idx, wd);
      end else begin
         send_item(OP_UNUSED, idx, wd);
      end
   endtask

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 100)
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
   endtask

   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rpcc_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rtc_results_due.size() == 0) begin
            note_mismatch("unexpected item read_data", '0, rsp_read_data);
         end else begin
            want = rtc_results_due.pop_front();
            if (rsp_read_data !== want.read_data)
               note_mismatch("read_data", want.read_data, rsp_read_data);
            if (rsp_irq_pulse !== want.irq_pulse)
               note_mismatch("irq_pulse", 32'(want.irq_pulse), 32'(rsp_irq_pulse));
            if (rsp_int_flag !== want.int_flag)
               note_mismatch("int_flag", 32'(want.int_flag), 32'(rsp_int_flag));
         end
      end
   end

   task automatic test_reset_values();
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_CTRL, '0);
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_CON, '0);
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_T14, '0);
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_ISNC, '0);
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_ALARM, '0);
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_ID, '0);
      send_item(rpcc_pkg::OP_READ, REG_UNUSED, '1);
   endtask

   task automatic test_register_writes();
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_CTRL, '1);
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_ID, '0);
      send_item(rpcc_pkg::OP_WRITE, REG_UNUSED, '1);
      send_item(OP_UNUSED, rpcc_pkg::REG_T14, '1);
   endtask

   task automatic test_overflow_chain();
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_CON, 32'(1 << rpcc_pkg::CON_RUN));
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_T14, '1);
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_REL, 32'h1234_5678);
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_CNT, '1);
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_ISNC, 32'(rpcc_pkg::EN_MASK));
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_ALARM, rpcc_pkg::ALARM_RESET);
      send_item(rpcc_pkg::OP_TICK, '0, '0);
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_CNT, '0);
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_ISNRC, 32'hFFF);
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_CTRL, 32'(1 << rpcc_pkg::CTRL_CLR_INT));
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_CON,
                32'((1 << rpcc_pkg::CON_RUN) | (1 << rpcc_pkg::CON_DEC)
                    | (1 << rpcc_pkg::CON_INC)));
      send_item(rpcc_pkg::OP_TICK, '1, '1);
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_CON,
                32'((1 << rpcc_pkg::CON_RUN) | (1 << rpcc_pkg::CON_INC)));
      send_item(rpcc_pkg::OP_TICK, '0, '0);
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_CON, '0);
      send_item(rpcc_pkg::OP_WRITE, rpcc_pkg::REG_CON, '0);
      send_item(rpcc_pkg::OP_TICK, '0, '0);
      send_item(rpcc_pkg::OP_READ, rpcc_pkg::REG_T14, '0);
   endtask

   task automatic test_backpressure();
      wait_idle();
      gap_pct = 0;
      hold_go = 1'b1;
      repeat (40) send_random_item();
      gap_pct = 25;
      wait_idle();
   endtask

   task automatic test_random_traffic();
      logic [15:0] loads[5];
      loads[0] = 16'hFFFF;
      loads[1] = 16'h0000;
      loads[2] = 16'($urandom);
      loads[3] = 16'hFFF8;
      loads[4] = rpcc_pkg::T14_RESET;
      for (int p = 0; p < 5; p++) begin
         load_t14_reset(loads[p]);
         gap_pct = (p == 2) ? 0 : 25;
         stall_pct = (p == 2) ? 0 : 25;
         repeat (300) send_random_item();
      end
      gap_pct = 25;
      stall_pct = 25;
   endtask

   initial begin
      ctl_bits = '0;
      mode = 4'((1 << rpcc_pkg::CON_RUN) | (1 << rpcc_pkg::CON_PRE));
      tick_cnt = rpcc_pkg::T14_RESET;
      tick_rel = rpcc_pkg::T14_RESET;
      cal_cnt = '0;
      cal_rel = '0;
      isn_bits = '0;
      alarm = rpcc_pkg::ALARM_RESET;
      pre_cnt = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_values();
      test_register_writes();
      test_overflow_chain();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      repeat (10) @(posedge clock);
      $display("Covered %0d items (%0d results checked), %0d tick counter reloads,",
               items_sent, results_seen, t14_loads);
      $display("%0d tick overflows and %0d interrupt pulses predicted", overflows, irqs_due);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== rtc_prescaler_calendar_counter_top.f =====
sv/rpcc_pkg.sv
sv/rpcc_core.sv
sv/rtc_prescaler_calendar_counter_top.sv
dv/tb_rtc_prescaler_calendar_counter_top.sv
